// ===== rtl/lffd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lffd_pkg
// Shared types, constants and helpers of the light flicker frame rate
// detector.
// ---------------------------------------------------------------------------
package lffd_pkg;

   localparam int FRAME_SLOTS = 128;
   localparam int SLOT_W      = $clog2(FRAME_SLOTS);
   localparam int ADC_W       = 16;
   localparam int TS_W        = 32;
   localparam int RATE_W      = 8;
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 72;

   localparam logic [ADC_W-1:0]  LEVEL_MAX         = 16'hFFFF;
   localparam logic [RATE_W-1:0] RATE_MAX          = 8'd255;
   localparam logic [TS_W-1:0]   INIT_PERIOD_RESET = 32'd1000;
   localparam logic [TS_W-1:0]   RATE_WINDOW_RESET = 32'd1000;

   localparam logic CSR_INIT_PERIOD = 1'b0;
   localparam logic CSR_RATE_WINDOW = 1'b1;

   typedef enum logic [1:0] {
      PH_GATHER = 2'd0,
      PH_BRIGHT = 2'd1,
      PH_DARK   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_COUNT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             frame;
      logic [ADC_W-1:0] dark_level;
      logic [ADC_W-1:0] dark_threshold;
      logic [ADC_W-1:0] bright_threshold;
      logic [ADC_W-1:0] bright_level;
   } level_type;

   // move a reference a quarter of the way toward target, guarded at both ends
   function automatic logic [ADC_W-1:0] nudge(input logic [ADC_W-1:0] ref_v,
                                              input logic [ADC_W-1:0] target);
      logic [ADC_W-1:0] step;
      logic [ADC_W:0]   sum;
      logic [ADC_W-1:0] res;
      res  = ref_v;
      step = '0;
      sum  = '0;
      if (target < ref_v) begin
         step = (ref_v - target) >> 2;
         if (step < ref_v) begin
            res = ref_v - step;
         end
      end else begin
         step = (target - ref_v) >> 2;
         sum  = {1'b0, ref_v} + {1'b0, step};
         if (sum < {1'b0, LEVEL_MAX}) begin
            res = sum[ADC_W-1:0];
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lffd_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lffd_cell
// One slot of the frame time chain: a stored time and its valid bit,
// passed on to the next cell whenever the chain moves.
// ---------------------------------------------------------------------------
module lffd_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire logic [lffd_pkg::TS_W-1:0] time_in,
   input  wire logic                   valid_in,
   output logic      [lffd_pkg::TS_W-1:0] time_out,
   output logic                        valid_out
);
   import lffd_pkg::*;

   logic [TS_W-1:0] time_ff;
   logic            valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         time_ff <= time_in;
      end
   end

   assign time_out  = time_ff;
   assign valid_out = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/lffd_level.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lffd_level
// Dark and bright reference tracking, thresholds and hysteresis frame
// detection for one sample.
// ---------------------------------------------------------------------------
module lffd_level (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        take,
   input  wire logic [lffd_pkg::ADC_W-1:0]  adc,
   input  wire logic [lffd_pkg::TS_W-1:0]   sample_ms,
   input  wire logic [lffd_pkg::TS_W-1:0]   init_period_ms,
   output lffd_pkg::level_type              lvl
);
   import lffd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [ADC_W-1:0] bright_ff, bright_in;
   logic [ADC_W-1:0] dark_ff, dark_in;
   logic [ADC_W-1:0] peak_ff, peak_in;
   logic [ADC_W-1:0] trough_ff, trough_in;
   logic [ADC_W-1:0] span, quarter, hi_thr, lo_thr;
   logic             frame;

   always_comb begin
      span      = bright_ff - dark_ff;
      quarter   = span >> 2;
      hi_thr    = bright_ff - quarter;
      lo_thr    = dark_ff + quarter;
      phase_in  = phase_ff;
      bright_in = bright_ff;
      dark_in   = dark_ff;
      peak_in   = peak_ff;
      trough_in = trough_ff;
      frame     = 1'b0;
      if (adc != '0) begin
         if (phase_ff == PH_GATHER) begin
            if (sample_ms < init_period_ms) begin
               if (adc > bright_ff) begin
                  bright_in = adc;
               end
               if (adc < dark_ff) begin
                  dark_in = adc;
               end
            end else begin
               if (adc < lo_thr) begin
                  phase_in = PH_DARK;
               end
               if (adc > hi_thr) begin
                  phase_in = PH_BRIGHT;
               end
            end
         end else begin
            if (phase_ff == PH_DARK) begin
               if (adc > hi_thr) begin
                  phase_in = PH_BRIGHT;
                  frame    = 1'b1;
                  if (trough_ff < hi_thr) begin
                     dark_in   = nudge(dark_ff, trough_ff);
                     trough_in = LEVEL_MAX;
                  end
               end else if (adc < trough_ff) begin
                  trough_in = adc;
               end
            end
            // same sample is seen again in the bright phase
            if (phase_in == PH_BRIGHT) begin
               if (adc < lo_thr) begin
                  phase_in = PH_DARK;
                  frame    = 1'b1;
                  if (peak_ff > lo_thr) begin
                     bright_in = nudge(bright_ff, peak_ff);
                     peak_in   = '0;
                  end
               end else if (adc > peak_ff) begin
                  peak_in = adc;
               end
            end
         end
      end
      lvl.frame            = frame;
      lvl.dark_level       = dark_in;
      lvl.dark_threshold   = lo_thr;
      lvl.bright_threshold = hi_thr;
      lvl.bright_level     = bright_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_GATHER;
         bright_ff <= '0;
         dark_ff   <= LEVEL_MAX;
         peak_ff   <= '0;
         trough_ff <= LEVEL_MAX;
      end else if (take) begin
         phase_ff  <= phase_in;
         bright_ff <= bright_in;
         dark_ff   <= dark_in;
         peak_ff   <= peak_in;
         trough_ff <= trough_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/light_flicker_frame_rate_detector.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// light_flicker_frame_rate_detector
// Flicker frame detector with a frame rate count over recent frame times.
// ---------------------------------------------------------------------------
// A sample that causes no frame is taken and the next sample can follow at
// once. A sample that causes a frame passes an insert state, a count pass
// over all FRAME_SLOTS slots and an output state that waits for a free
// response register; no new sample is taken until the result is in the
// output register: the stored frame times live in a chain of cells that is
// rotated once around, one stored time passing the age comparator per
// cycle. Reset clears the slot valid bits at once; there is no clearing pass.
module light_flicker_frame_rate_detector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // adc [15:0], sample_ms [47:16]
   input  wire logic [lffd_pkg::REQ_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // frame_rate [7:0], dark_level [23:8], dark_threshold [39:24],
   // bright_threshold [55:40], bright_level [71:56]
   output logic      [lffd_pkg::RSP_W-1:0]    rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic                          csr_addr,
   input  wire logic [lffd_pkg::TS_W-1:0]     csr_wdata
);
   import lffd_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

   state_type          state_ff, state_in;
   logic [TS_W-1:0]    init_period_ff, rate_window_ff;
   logic [TS_W-1:0]    ts_ff;
   level_type          res_ff;
   logic [RATE_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic               load_rsp;

   logic               accept;
   logic [ADC_W-1:0]   adc;
   logic [TS_W-1:0]    sample_ms;
   level_type          lvl;

   logic               shift_en;
   logic [TS_W-1:0]    head_time;
   logic               head_valid;
   logic [TS_W-1:0]    cell_time  [FRAME_SLOTS];
   logic               cell_valid [FRAME_SLOTS];
   logic [TS_W-1:0]    tail_time;
   logic [TS_W-1:0]    age;
   logic               hit;

   assign adc          = req_tdata[ADC_W-1:0];
   assign sample_ms    = req_tdata[ADC_W+TS_W-1:ADC_W];
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_period_ff <= INIT_PERIOD_RESET;
         rate_window_ff <= RATE_WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_INIT_PERIOD: init_period_ff <= csr_wdata;
            CSR_RATE_WINDOW: rate_window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   lffd_level u_level (
      .clock          (clock),
      .reset          (reset),
      .take           (accept),
      .adc            (adc),
      .sample_ms      (sample_ms),
      .init_period_ms (init_period_ff),
      .lvl            (lvl)
   );

   // chain: new time enters at the head, or the chain rotates tail to head
   assign shift_en   = (state_ff == ST_INSERT) || (state_ff == ST_COUNT);
   assign head_time  = (state_ff == ST_INSERT) ? ts_ff : cell_time[FRAME_SLOTS-1];
   assign head_valid = (state_ff == ST_INSERT) ? 1'b1 : cell_valid[FRAME_SLOTS-1];

   for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_head
         lffd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .time_in   (head_time),
            .valid_in  (head_valid),
            .time_out  (cell_time[i]),
            .valid_out (cell_valid[i])
         );
      end else begin : g_body
         lffd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .time_in   (cell_time[i-1]),
            .valid_in  (cell_valid[i-1]),
            .time_out  (cell_time[i]),
            .valid_out (cell_valid[i])
         );
      end
   end

   assign tail_time = cell_valid[FRAME_SLOTS-1] ? cell_time[FRAME_SLOTS-1] : '0;
   assign age       = ts_ff - tail_time;
   assign hit       = (age < rate_window_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      load_rsp     = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && lvl.frame) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            count_in = '0;
            step_in  = '0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (hit && (count_ff != RATE_MAX)) begin
               count_in = count_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_SLOT) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ts_ff  <= sample_ms;
         res_ff <= lvl;
      end
      if (load_rsp) begin
         rsp_data_ff <= {res_ff.bright_level, res_ff.bright_threshold,
                         res_ff.dark_threshold, res_ff.dark_level, count_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_frame_starts_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && lvl.frame) |=> (state_ff == ST_INSERT))
      else $error("frame transfer did not start insertion");

   a_insert_fills_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> (cell_valid[0] && (cell_time[0] == $past(ts_ff))))
      else $error("head cell not loaded with frame time");

   a_count_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && step_ff != LAST_SLOT) |=> (state_ff == ST_COUNT))
      else $error("count pass left early");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_tready) |=>
      (state_ff == ST_OUT && $stable(rsp_tdata)))
      else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire

// ===== dv/tb_light_flicker_frame_rate_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_flicker_frame_rate_detector
// Self-checking bench for the light flicker frame rate detector. A short
// stimulus table covers the start period, the hand-off to the hysteresis
// detector, threshold boundaries, both reference adjustments, the cleared
// frame time ring and timestamp wrap. Random light waveforms follow. They
// swing around the live thresholds with noise, and run under several
// settings of both registers. Every result transfer is compared field by
// field with an in-bench predictor, or with the table entry of a typed row.
// ----------------------------------------------------------------------------
module tb_light_flicker_frame_rate_detector;
   import lffd_pkg::*;

   // packed so that the layout matches rsp_tdata, frame_rate in the low bits
   typedef struct packed {
      logic [ADC_W-1:0]  bright_level;
      logic [ADC_W-1:0]  bright_threshold;
      logic [ADC_W-1:0]  dark_threshold;
      logic [ADC_W-1:0]  dark_level;
      logic [RATE_W-1:0] frame_rate;
   } level_rec;

   typedef struct packed {
      logic [ADC_W-1:0] adc;
      logic [TS_W-1:0]  stamp;
      logic             typed;
      level_rec         want;
   } probe_row;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tready = 1'b0;
   logic              csr_we     = 1'b0;
   logic              csr_addr   = CSR_INIT_PERIOD;
   logic [TS_W-1:0]   csr_wdata  = '0;
   logic              req_tready;
   logic              rsp_tvalid;
   logic [RSP_W-1:0]  rsp_tdata;

   bit                steady         = 1'b0;
   int unsigned       mismatch_count = 0;
   level_rec          expected_levels[$];

   // predictor state
   phase_type         lvl_phase;
   logic [ADC_W-1:0]  bright_ref_q;
   logic [ADC_W-1:0]  dark_ref_q;
   logic [ADC_W-1:0]  peak_q;
   logic [ADC_W-1:0]  trough_q;
   logic [TS_W-1:0]   stamp_ring[FRAME_SLOTS];
   int unsigned       ring_slot;
   logic [TS_W-1:0]   init_period_q;
   logic [TS_W-1:0]   rate_window_q;

   probe_row probe_table[22] = '{
      '{16'h0000, 32'd0,          1'b0, '0},
      '{16'h8000, 32'd0,          1'b0, '0},
      '{16'hFFFF, 32'd20,         1'b0, '0},
      '{16'h0001, 32'd30,         1'b0, '0},
      '{16'h0000, 32'd100,        1'b0, '0},   // zero at the end of start period
      '{16'h2000, 32'd100,        1'b0, '0},   // leaves start period, picks dark
      '{16'h42FF, 32'd105,        1'b0, '0},
      '{16'h1000, 32'd110,        1'b0, '0},
      '{16'hC000, 32'd115,        1'b0, '0},   // on the bright threshold
      '{16'hD000, 32'd120,        1'b1,        // first frame, cleared ring counts
        '{bright_level: 16'hFFFF, bright_threshold: 16'hC000,
          dark_threshold: 16'h4000, dark_level: 16'h0400, frame_rate: 8'd128}},
      '{16'hFFFF, 32'd130,        1'b0, '0},
      '{16'h0001, 32'd140,        1'b0, '0},   // bright ref held at the top
      '{16'h3000, 32'd150,        1'b0, '0},
      '{16'hC101, 32'd170,        1'b0, '0},
      '{16'h4B3F, 32'd180,        1'b0, '0},   // on the dark threshold
      '{16'h4B3E, 32'd190,        1'b0, '0},
      '{16'h0001, 32'd5000,       1'b0, '0},
      '{16'hFFFF, 32'd5001,       1'b0, '0},
      '{16'h0001, 32'hFFFF_FFFF,  1'b0, '0},
      '{16'hFFFF, 32'd5,          1'b0, '0},   // timestamp wrap
      '{16'h8000, 32'd50,         1'b0, '0},   // below start period, detector live
      '{16'h0000, 32'd60,         1'b0, '0}
   };

   light_flicker_frame_rate_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [ADC_W-1:0] ease_toward(input logic [ADC_W-1:0] level,
                                                    input logic [ADC_W-1:0] goal);
      logic [ADC_W-1:0] step;
      logic [ADC_W:0]   sum;
      if (goal < level) begin
         step = (level - goal) >> 2;
         return (step < level) ? level - step : level;
      end
      step = (goal - level) >> 2;
      sum  = {1'b0, level} + {1'b0, step};
      return (sum < {1'b0, LEVEL_MAX}) ? sum[ADC_W-1:0] : level;
   endfunction

   function automatic void level_thresholds(output logic [ADC_W-1:0] lo_thr,
                                            output logic [ADC_W-1:0] hi_thr);
      logic [ADC_W-1:0] quarter;
      quarter = (bright_ref_q - dark_ref_q) >> 2;
      hi_thr  = bright_ref_q - quarter;
      lo_thr  = dark_ref_q + quarter;
   endfunction

   // advances the predictor by one sample; returns 1 when a frame is reported
   function automatic bit flicker_step(input logic [ADC_W-1:0] adc,
                                       input logic [TS_W-1:0] stamp,
                                       output level_rec res);
      logic [ADC_W-1:0] lo_thr;
      logic [ADC_W-1:0] hi_thr;
      bit               frame;
      int unsigned      hits;
      res   = '0;
      frame = 1'b0;
      hits  = 0;
      if (adc == '0) return 1'b0;
      if (lvl_phase == PH_GATHER && stamp < init_period_q) begin
         if (adc > bright_ref_q) bright_ref_q = adc;
         if (adc < dark_ref_q) dark_ref_q = adc;
         return 1'b0;
      end
      level_thresholds(lo_thr, hi_thr);
      if (lvl_phase == PH_GATHER) begin
         if (adc < lo_thr) lvl_phase = PH_DARK;
         if (adc > hi_thr) lvl_phase = PH_BRIGHT;
         return 1'b0;
      end
      if (lvl_phase == PH_DARK) begin
         if (adc > hi_thr) begin
            lvl_phase = PH_BRIGHT;
            frame     = 1'b1;
            if (trough_q < hi_thr) begin
               dark_ref_q = ease_toward(dark_ref_q, trough_q);
               trough_q   = LEVEL_MAX;
            end
         end else if (adc < trough_q) begin
            trough_q = adc;
         end
      end
      // same sample is seen again right after a dark-to-bright crossing
      if (lvl_phase == PH_BRIGHT) begin
         if (adc < lo_thr) begin
            lvl_phase = PH_DARK;
            frame     = 1'b1;
            if (peak_q > lo_thr) begin
               bright_ref_q = ease_toward(bright_ref_q, peak_q);
               peak_q       = '0;
            end
         end else if (adc > peak_q) begin
            peak_q = adc;
         end
      end
      if (!frame) return 1'b0;
      stamp_ring[ring_slot] = stamp;
      foreach (stamp_ring[k]) begin
         if (stamp - stamp_ring[k] < rate_window_q && hits < RATE_MAX) hits++;
      end
      ring_slot            = (ring_slot + 1) % FRAME_SLOTS;
      res.frame_rate       = hits[RATE_W-1:0];
      res.dark_level       = dark_ref_q;
      res.dark_threshold   = lo_thr;
      res.bright_threshold = hi_thr;
      res.bright_level     = bright_ref_q;
      return 1'b1;
   endfunction

   // light level on the requested side of the live thresholds, with noise
   function automatic logic [ADC_W-1:0] pick_level(input bit bright_side);
      logic [ADC_W-1:0] lo_thr;
      logic [ADC_W-1:0] hi_thr;
      int unsigned      lo_v;
      int unsigned      hi_v;
      int unsigned      roll;
      level_thresholds(lo_thr, hi_thr);
      lo_v = lo_thr;
      hi_v = hi_thr;
      roll = $urandom_range(99);
      if (roll < 12) return ADC_W'($urandom_range(1, 65535));
      if (roll < 20 && lo_v <= hi_v && lo_v != 0) begin
         return ADC_W'($urandom_range(lo_v, hi_v));
      end
      if (roll < 25) return bright_side ? LEVEL_MAX : 16'd1;
      if (bright_side) begin
         return (hi_v >= 65535) ? LEVEL_MAX : ADC_W'($urandom_range(hi_v + 1, 65535));
      end
      return (lo_v <= 1) ? 16'd1 : ADC_W'($urandom_range(1, lo_v - 1));
   endfunction

   task automatic write_csr(input logic addr, input logic [TS_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_INIT_PERIOD) init_period_q = value;
      else rate_window_q = value;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TS_W-1:0] stamp,
                              input logic typed, input level_rec want);
      level_rec pred;
      while (!steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, adc};
      do @(posedge clock); while (!req_tready);
      if (flicker_step(adc, stamp, pred) && !typed) expected_levels.push_back(pred);
      if (typed) expected_levels.push_back(want);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (FRAME_SLOTS + 12) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [ADC_W-1:0] want,
                              input logic [ADC_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      level_rec got;
      level_rec want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_levels.size() == 0) begin
            $display("%0t ns: result transfer with none expected, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_levels.pop_front();
            check_field("frame_rate", want.frame_rate, got.frame_rate);
            check_field("dark_level", want.dark_level, got.dark_level);
            check_field("dark_threshold", want.dark_threshold, got.dark_threshold);
            check_field("bright_threshold", want.bright_threshold, got.bright_threshold);
            check_field("bright_level", want.bright_level, got.bright_level);
         end
      end
   end

   initial begin
      int unsigned      ph;
      int unsigned      sent;
      int unsigned      burst;
      int unsigned      roll;
      logic [TS_W-1:0]  now_ts;
      logic [TS_W-1:0]  window;
      logic [TS_W-1:0]  start_gate;
      logic [ADC_W-1:0] adc;
      bit               bright_side;
      lvl_phase     = PH_GATHER;
      bright_ref_q  = '0;
      dark_ref_q    = LEVEL_MAX;
      peak_q        = '0;
      trough_q      = LEVEL_MAX;
      ring_slot     = 0;
      init_period_q = INIT_PERIOD_RESET;
      rate_window_q = RATE_WINDOW_RESET;
      foreach (stamp_ring[k]) stamp_ring[k] = '0;
      now_ts      = 32'd100;
      burst       = 0;
      bright_side = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_INIT_PERIOD, 32'd100);

      foreach (probe_table[i]) begin
         send_sample(probe_table[i].adc, probe_table[i].stamp,
                     probe_table[i].typed, probe_table[i].want);
      end

      for (ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: window = RATE_WINDOW_RESET;
            1: window = 32'd1;
            2: window = '1;
            3: window = '0;
            4: window = $urandom_range(50, 4000);
            default: window = $urandom();
         endcase
         case (ph)
            0: start_gate = '0;
            1: start_gate = '1;
            default: start_gate = $urandom();
         endcase
         write_csr(CSR_RATE_WINDOW, window);
         write_csr(CSR_INIT_PERIOD, start_gate);
         steady = (ph == 2);
         sent   = 0;
         while (sent < 315) begin
            roll = $urandom_range(99);
            if (roll < 84) now_ts = now_ts + $urandom_range(1, 40);
            else if (roll < 90) now_ts = now_ts + $urandom_range(41, 3000);
            else if (roll < 94) now_ts = $urandom();
            else if (roll < 97) now_ts = '1 - $urandom_range(0, 200);
            if ($urandom_range(99) < 4) begin
               send_sample('0, now_ts, 1'b0, '0);
            end else begin
               if (burst == 0) begin
                  bright_side = !bright_side;
                  burst       = $urandom_range(1, 6);
               end
               burst--;
               adc = pick_level(bright_side);
               send_sample(adc, now_ts, 1'b0, '0);
               sent++;
            end
         end
      end
      steady = 1'b0;
      drain();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
